// ===== design/slps_pkg.sv =====
`default_nettype none

package slps_pkg;

  localparam int unsigned HOLD_WIDTH_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned SEG_W          = 10;
  localparam logic [CFG_W-1:0] HOLD_RESET = CFG_W'(5000);
  localparam logic [SEG_W-1:0] SEG_RESET  = SEG_W'(100);

  // event codes
  localparam logic [3:0] EV_TARGET_ON  = 4'd0;
  localparam logic [3:0] EV_TARGET_OFF = 4'd1;
  localparam logic [3:0] EV_STORE_ON   = 4'd2;
  localparam logic [3:0] EV_STORE_OFF  = 4'd3;
  localparam logic [3:0] EV_V1_ON      = 4'd4;
  localparam logic [3:0] EV_V1_OFF     = 4'd5;
  localparam logic [3:0] EV_V2_ON      = 4'd6;
  localparam logic [3:0] EV_V2_OFF     = 4'd7;
  localparam logic [3:0] EV_RTT_BLOCK  = 4'd8;
  localparam logic [3:0] EV_RTT_DATA   = 4'd9;
  localparam logic [3:0] EV_UART_DATA  = 4'd10;

  // link flag bits
  localparam int unsigned FL_TARGET  = 0;
  localparam int unsigned FL_STORAGE = 1;
  localparam int unsigned FL_V1      = 2;
  localparam int unsigned FL_V2      = 3;

  typedef enum logic [2:0] {
    PAT_SEARCH  = 3'd0,
    PAT_V1      = 3'd1,
    PAT_V2      = 3'd2,
    PAT_STORAGE = 3'd3,
    PAT_UART    = 3'd4,
    PAT_RTT     = 3'd5
  } pat_e;

  typedef struct packed {
    logic       action;
    logic [3:0] code;
  } item_t;

  typedef struct packed {
    pat_e pattern;
    logic led;
  } res_t;

  function automatic logic [2:0] seg_total(pat_e p, logic [1:0] n);
    logic [2:0] t;
    case (p)
      PAT_SEARCH:  t = 3'd2;
      PAT_V1:      t = 3'd2;
      PAT_V2:      t = 3'd4;
      PAT_STORAGE: t = 3'd6;
      PAT_UART:    t = 3'd2;
      default:     t = {n, 1'b1};
    endcase
    return t;
  endfunction

  function automatic logic seg_level(pat_e p, logic [2:0] i, logic [1:0] n);
    logic l;
    case (p)
      PAT_SEARCH, PAT_V1, PAT_V2, PAT_STORAGE: l = i[0];
      PAT_UART: l = (i == 3'd0);
      default:  l = (i < {n, 1'b0}) ? ~i[0] : 1'b0;
    endcase
    return l;
  endfunction

  function automatic logic [SEG_W-1:0] seg_length(pat_e p, logic [2:0] i, logic [1:0] n);
    logic [2:0]       last;
    logic [SEG_W-1:0] len;
    last = seg_total(p, n) - 3'd1;
    case (p)
      PAT_SEARCH:  len = SEG_W'(100);
      PAT_V1:      len = (i < last) ? SEG_W'(100) : SEG_W'(900);
      PAT_V2:      len = (i < last) ? SEG_W'(100) : SEG_W'(700);
      PAT_STORAGE: len = (i < last) ? SEG_W'(100) : SEG_W'(500);
      PAT_UART:    len = (i == 3'd0) ? SEG_W'(300) : SEG_W'(700);
      default: begin
        if (i < {n, 1'b0}) begin
          len = i[0] ? SEG_W'(200) : SEG_W'(20);
        end else begin
          // frame closes with 1000 ms minus the flashes shown
          case (n)
            2'd0:    len = SEG_W'(1000);
            2'd1:    len = SEG_W'(780);
            2'd2:    len = SEG_W'(560);
            default: len = SEG_W'(340);
          endcase
        end
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/slps_in_stage.sv =====
`default_nettype none

module slps_in_stage
  import slps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  output      logic       s_ready_o,
  input  wire logic       action_i,
  input  wire logic [3:0] code_i,
  input  wire logic       adv_i,
  output      logic       step_o,
  output      item_t      item_o
);

  logic  vld_q;
  item_t item_q;

  assign s_ready_o = !vld_q || adv_i;
  assign step_o    = vld_q && adv_i;
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_ready_o) begin
      vld_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      item_q <= '{action: action_i, code: code_i};
    end
  end

endmodule

`default_nettype wire

// ===== design/slps_core.sv =====
`default_nettype none

module slps_core
  import slps_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HOLD_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire item_t            item_i,
  input  wire logic [CFG_W-1:0] hold_cfg_i,
  output      res_t             res_o
);

  localparam int unsigned CMP_W = (HOLD_WIDTH > CFG_W) ? HOLD_WIDTH : CFG_W;
  localparam logic [HOLD_WIDTH-1:0] HoldMax = '1;
  localparam logic [HOLD_WIDTH-1:0] HoldRst =
    (CMP_W'(HOLD_RESET) > CMP_W'(HoldMax)) ? HoldMax : HOLD_WIDTH'(CMP_W'(HOLD_RESET));

  logic [3:0]            flags_q, flags_d;
  logic [1:0]            flash_q, flash_d;
  logic [HOLD_WIDTH-1:0] uart_q, uart_d, rtt_q, rtt_d;
  pat_e                  pat_q, pat_d;
  logic [2:0]            idx_q, idx_d;
  logic [SEG_W-1:0]      left_q, left_d;
  logic [1:0]            lat_q, lat_d;
  logic                  led_q, led_d;

  logic [HOLD_WIDTH-1:0] hold_load, uart_dec, rtt_dec;
  logic [SEG_W-1:0]      left_dec;
  pat_e                  pick;
  logic [1:0]            pick_lat;

  always_comb begin
    hold_load = (CMP_W'(hold_cfg_i) > CMP_W'(HoldMax)) ? HoldMax
                                                        : HOLD_WIDTH'(CMP_W'(hold_cfg_i));
    uart_dec = (uart_q != '0) ? uart_q - 1'b1 : uart_q;
    rtt_dec  = (rtt_q != '0) ? rtt_q - 1'b1 : rtt_q;
    left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

    // priority pick on the flags and the counted-down timers
    if (!flags_q[FL_TARGET])     pick = PAT_SEARCH;
    else if (flags_q[FL_V1])     pick = PAT_V1;
    else if (flags_q[FL_V2])     pick = PAT_V2;
    else if (flags_q[FL_STORAGE]) pick = PAT_STORAGE;
    else if (uart_dec != '0)     pick = PAT_UART;
    else                         pick = PAT_RTT;
    pick_lat = (pick != PAT_RTT) ? 2'd0 : (rtt_dec != '0) ? 2'd3 : flash_q;

    flags_d = flags_q;
    flash_d = flash_q;
    uart_d  = uart_q;
    rtt_d   = rtt_q;
    pat_d   = pat_q;
    idx_d   = idx_q;
    left_d  = left_q;
    lat_d   = lat_q;
    led_d   = led_q;

    if (item_i.action) begin
      case (item_i.code)
        EV_TARGET_ON: begin
          flags_d[FL_TARGET] = 1'b1;
          flash_d = 2'd1;
        end
        EV_TARGET_OFF: flags_d[FL_TARGET] = 1'b0;
        EV_STORE_ON: begin
          flags_d[FL_STORAGE] = 1'b1;
          flash_d = 2'd0;
        end
        EV_STORE_OFF: flags_d[FL_STORAGE] = 1'b0;
        EV_V1_ON: begin
          flags_d[FL_V1] = 1'b1;
          flash_d = 2'd0;
        end
        EV_V1_OFF: flags_d[FL_V1] = 1'b0;
        EV_V2_ON: begin
          flags_d[FL_V2] = 1'b1;
          flash_d = 2'd0;
        end
        EV_V2_OFF:    flags_d[FL_V2] = 1'b0;
        EV_RTT_BLOCK: flash_d = 2'd2;
        EV_RTT_DATA:  rtt_d = hold_load;
        EV_UART_DATA: uart_d = hold_load;
        default: ;
      endcase
    end else begin
      uart_d = uart_dec;
      rtt_d  = rtt_dec;
      left_d = left_dec;
      if (left_dec == '0) begin
        if ({1'b0, idx_q} + 4'd1 >= {1'b0, seg_total(pat_q, lat_q)}) begin
          pat_d  = pick;
          lat_d  = pick_lat;
          idx_d  = 3'd0;
          led_d  = seg_level(pick, 3'd0, pick_lat);
          left_d = seg_length(pick, 3'd0, pick_lat);
        end else begin
          idx_d  = idx_q + 3'd1;
          led_d  = seg_level(pat_q, idx_q + 3'd1, lat_q);
          left_d = seg_length(pat_q, idx_q + 3'd1, lat_q);
        end
      end
    end
  end

  assign res_o = '{pattern: pat_d, led: led_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      flash_q <= 2'd0;
      uart_q  <= HoldRst;
      rtt_q   <= HoldRst;
      pat_q   <= PAT_SEARCH;
      idx_q   <= 3'd0;
      left_q  <= SEG_RESET;
      lat_q   <= 2'd0;
      led_q   <= 1'b0;
    end else if (step_i) begin
      flags_q <= flags_d;
      flash_q <= flash_d;
      uart_q  <= uart_d;
      rtt_q   <= rtt_d;
      pat_q   <= pat_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      lat_q   <= lat_d;
      led_q   <= led_d;
    end
  end

  a_event_keeps_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action |=> $stable(led_q) && $stable(pat_q))
    else $error("event changed LED or pattern");

  a_seg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q != '0)
    else $error("segment timer reached zero without reload");

  a_lat_only_rtt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_q != PAT_RTT |-> lat_q == 2'd0)
    else $error("flash count latched outside flash pattern");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < seg_total(pat_q, lat_q))
    else $error("segment index past end of pattern");

endmodule

`default_nettype wire

// ===== design/slps_out_stage.sv =====
`default_nettype none

module slps_out_stage
  import slps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire res_t       res_i,
  output      logic       adv_o,
  output      logic       m_valid_o,
  input  wire logic       m_ready_i,
  output      logic [7:0] m_data_o
);

  logic vld_q;
  res_t res_q;

  assign adv_o     = !vld_q || m_ready_i;
  assign m_valid_o = vld_q;
  assign m_data_o  = {4'b0000, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (step_i) begin
      vld_q <= 1'b1;
    end else if (m_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/status_led_pattern_sequencer.sv =====
`default_nettype none

// Status LED pattern sequencer. Each input item is a 1 ms tick (tuser = 0) or a
// status event (tuser = 1, code in tdata[3:0]); every item yields exactly one
// result item carrying the LED level and the pattern being shown after it.
// One item is taken per clock cycle while the output does not stall; an accepted
// item sits in the input register, passes through the combinational state update
// and lands in the result register, which then offers it. Output stalls back up
// into the input once both registers are full. The user must write the activity
// hold time through cfg_we_i/cfg_wdata_i only while the stream is idle; the block
// does not enforce this. UART and RTT hold timers start at HOLD_RESET at reset.
module status_led_pattern_sequencer
  import slps_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HOLD_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // [3:0] event_code
  input  wire logic             s_axis_tuser,  // [0] action
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [7:0]       m_axis_tdata,  // [0] led_on, [3:1] pattern_shown
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] hold_cfg_q;
  logic             adv, step;
  item_t            item;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_cfg_q <= cfg_wdata_i;
    end
  end

  slps_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser),
    .code_i    (s_axis_tdata[3:0]),
    .adv_i     (adv),
    .step_o    (step),
    .item_o    (item)
  );

  slps_core #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .hold_cfg_i (hold_cfg_q),
    .res_o      (res)
  );

  slps_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_i     (res),
    .adv_o     (adv),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output could move");

endmodule

`default_nettype wire

// ===== sim/led_pattern_checker.sv =====
`timescale 1ns / 1ps

module led_pattern_checker
  import slps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  input  wire logic             s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // [3:0] event_code
  input  wire logic             s_axis_tuser,  // [0] action
  input  wire logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic [7:0]       m_axis_tdata,  // [0] led_on, [3:1] pattern_shown
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    pat_e pattern;
    logic led;
  } led_view_t;

  led_view_t        shown_q[$];

  logic [CFG_W-1:0] hold_ms;
  logic [3:0]       links;
  logic [1:0]       flashes;
  logic [CFG_W-1:0] uart_left;
  logic [CFG_W-1:0] rtt_left;
  pat_e             pat;
  logic [2:0]       seg_idx;
  logic [SEG_W-1:0] seg_left;
  logic [1:0]       frame_flashes;
  logic             led;

  function automatic logic [2:0] segments_in(pat_e p, logic [1:0] n);
    case (p)
      PAT_V2:      return 3'd4;
      PAT_STORAGE: return 3'd6;
      PAT_RTT:     return 3'(2 * n + 1);
      default:     return 3'd2;
    endcase
  endfunction

  task automatic load_segment();
    logic [2:0] last;
    last = segments_in(pat, frame_flashes) - 3'd1;
    case (pat)
      PAT_UART: begin
        led      = (seg_idx == 3'd0);
        seg_left = (seg_idx == 3'd0) ? SEG_W'(300) : SEG_W'(700);
      end
      PAT_RTT: begin
        if (seg_idx < {frame_flashes, 1'b0}) begin
          led      = ~seg_idx[0];
          seg_left = seg_idx[0] ? SEG_W'(200) : SEG_W'(20);
        end else begin
          // close the frame with whatever the shown flashes left of 1000 ms
          led      = 1'b0;
          seg_left = SEG_W'(1000 - 220 * frame_flashes);
        end
      end
      default: begin
        led = seg_idx[0];
        if (pat == PAT_SEARCH || seg_idx < last) begin
          seg_left = SEG_W'(100);
        end else if (pat == PAT_V1) begin
          seg_left = SEG_W'(900);
        end else if (pat == PAT_V2) begin
          seg_left = SEG_W'(700);
        end else begin
          seg_left = SEG_W'(500);
        end
      end
    endcase
  endtask

  task automatic pick_next_pattern();
    if (!links[FL_TARGET]) begin
      pat = PAT_SEARCH;
    end else if (links[FL_V1]) begin
      pat = PAT_V1;
    end else if (links[FL_V2]) begin
      pat = PAT_V2;
    end else if (links[FL_STORAGE]) begin
      pat = PAT_STORAGE;
    end else if (uart_left != '0) begin
      pat = PAT_UART;
    end else begin
      pat = PAT_RTT;
    end
    if (pat != PAT_RTT) begin
      frame_flashes = 2'd0;
    end else begin
      frame_flashes = (rtt_left != '0) ? 2'd3 : flashes;
    end
    seg_idx = 3'd0;
    load_segment();
  endtask

  task automatic apply_tick();
    // timers first, so the pattern choice sees them after this tick
    if (uart_left != '0) uart_left = uart_left - 1'b1;
    if (rtt_left != '0) rtt_left = rtt_left - 1'b1;
    if (seg_left != '0) seg_left = seg_left - 1'b1;
    if (seg_left == '0) begin
      if (seg_idx + 1 >= segments_in(pat, frame_flashes)) begin
        pick_next_pattern();
      end else begin
        seg_idx = seg_idx + 3'd1;
        load_segment();
      end
    end
  endtask

  task automatic apply_status(logic [3:0] code);
    case (code)
      EV_TARGET_ON: begin
        links[FL_TARGET] = 1'b1;
        flashes          = 2'd1;
      end
      EV_TARGET_OFF: links[FL_TARGET] = 1'b0;
      EV_STORE_ON: begin
        links[FL_STORAGE] = 1'b1;
        flashes           = 2'd0;
      end
      EV_STORE_OFF: links[FL_STORAGE] = 1'b0;
      EV_V1_ON: begin
        links[FL_V1] = 1'b1;
        flashes      = 2'd0;
      end
      EV_V1_OFF: links[FL_V1] = 1'b0;
      EV_V2_ON: begin
        links[FL_V2] = 1'b1;
        flashes      = 2'd0;
      end
      EV_V2_OFF:    links[FL_V2] = 1'b0;
      EV_RTT_BLOCK: flashes = 2'd2;
      EV_RTT_DATA:  rtt_left = hold_ms;
      EV_UART_DATA: uart_left = hold_ms;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    led_view_t want;
    led_view_t now_shown;
    if (!rst_ni) begin
      hold_ms       = HOLD_RESET;
      links         = 4'd0;
      flashes       = 2'd0;
      uart_left     = HOLD_RESET;
      rtt_left      = HOLD_RESET;
      pat           = PAT_SEARCH;
      seg_idx       = 3'd0;
      seg_left      = SEG_RESET;
      frame_flashes = 2'd0;
      led           = 1'b0;
      shown_q.delete();
      fail_count_o  = 0;
    end else begin
      if (cfg_we_i) hold_ms = cfg_wdata_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (shown_q.size() == 0) begin
          $error("result with nothing expected: tdata=%h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = shown_q.pop_front();
          if (m_axis_tdata[0] !== want.led) begin
            $error("led_on: expected %0d, actual %0d", want.led, m_axis_tdata[0]);
            fail_count_o++;
          end
          if (m_axis_tdata[3:1] !== 3'(want.pattern)) begin
            $error("pattern_shown: expected %0d, actual %0d",
                   3'(want.pattern), m_axis_tdata[3:1]);
            fail_count_o++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          apply_status(s_axis_tdata[3:0]);
        end else begin
          apply_tick();
        end
        now_shown.pattern = pat;
        now_shown.led     = led;
        shown_q.push_back(now_shown);
      end
    end
    pending_o = shown_q.size();
  end

endmodule

// ===== sim/tb_status_led_pattern_sequencer.sv =====
`timescale 1ns / 1ps

module tb_status_led_pattern_sequencer;
  import slps_pkg::*;

  localparam int unsigned PHASES          = 5;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned STALL_LIMIT     = 3000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'd0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int               fail_count;
  int               pending;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      hold_asked = 0;
  int unsigned      hold_done = 0;
  int unsigned      rx_hold_left = 0;
  int unsigned      quiet_cycles = 0;

  logic [3:0] opening_events [14] = '{
    4'd15, 4'd11, EV_TARGET_ON, EV_RTT_BLOCK, EV_STORE_ON, EV_STORE_OFF,
    EV_V1_ON, EV_V1_OFF, EV_V2_ON, EV_V2_OFF, EV_RTT_DATA, EV_UART_DATA,
    EV_TARGET_OFF, EV_TARGET_ON
  };
  logic [CFG_W-1:0] phase_hold_ms [PHASES] = '{
    CFG_W'(0), CFG_W'(150), CFG_W'(65535), CFG_W'(1), CFG_W'(0)
  };

  status_led_pattern_sequencer uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  led_pattern_checker led_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_tready = 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done++;
      rx_hold_left = HOLD_OFF_CYCLES - 1;
      m_tready     = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; leaves tvalid high so back-to-back items need no drop
  task automatic send_item(input logic action, input logic [3:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = action;
    s_tdata  = {4'd0, code};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_hold(input logic [CFG_W-1:0] ms);
    cfg_we    = 1'b1;
    cfg_wdata = ms;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    if ($urandom_range(99) < 88) begin
      send_item(1'b0, 4'($urandom_range(15)));
    end else begin
      // lean toward target found so the link patterns get shown
      pick = $urandom_range(23);
      send_item(1'b1, (pick < 16) ? 4'(pick) : EV_TARGET_ON);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(1'b0, 4'd15);
    foreach (opening_events[i]) send_item(1'b1, opening_events[i]);
    send_item(1'b0, 4'd0);
    repeat (6) send_item(1'b0, 4'($urandom_range(15)));
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        3:       begin tx_idle_pct = 37; rx_stall_pct = 37; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      write_hold(phase_hold_ms[ph]);
      // reload both activity timers with this phase's hold time
      send_item(1'b1, EV_UART_DATA);
      send_item(1'b1, EV_RTT_DATA);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 4 && n == 40) hold_asked++;
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_random_item();
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== status_led_pattern_sequencer.f =====
design/slps_pkg.sv
design/slps_in_stage.sv
design/slps_core.sv
design/slps_out_stage.sv
design/status_led_pattern_sequencer.sv
sim/led_pattern_checker.sv
sim/tb_status_led_pattern_sequencer.sv
